// ===== hdl/vfa_pkg.sv =====
// Shared types, codes and helpers for the fixed-point vector unit.
package vfa_pkg;

	localparam int COMPONENTS = 3;
	localparam int FRAC_BITS  = 16;
	localparam int SQRT_CELLS = 32;
	localparam int DIV_BITS   = 17;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_SUB    = 3'd1,
		CMD_DOT    = 3'd2,
		CMD_SCALE  = 3'd3,
		CMD_LENGTH = 3'd4,
		CMD_NORM   = 3'd5,
		CMD_NEG    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		logic [31:0] val;
		logic        ov;
	} sat_t;

	// One transaction as it travels down the chain of cells
	typedef struct packed {
		logic                                  valid;
		cmd_t                                  cmd;
		logic                                  ov;
		logic [COMPONENTS-1:0][31:0]           r;
		logic [31:0]                           scal;
		logic [63:0]                           n;
		logic [35:0]                           rem;
		logic [31:0]                           root;
		logic [COMPONENTS-1:0]                 neg;
		logic [COMPONENTS-1:0][47:0]           drem;
		logic [COMPONENTS-1:0][DIV_BITS-1:0]   quo;
	} token_t;

	// Saturate a wide signed value to the signed 32-bit range
	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t s;
		s.ov = (v[65:31] != {35{v[31]}});
		if (s.ov) begin
			s.val = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			s.val = v[31:0];
		end
		return s;
	endfunction

endpackage

// ===== hdl/vfa_front.sv =====
// Front end: per-lane multiply, then add, saturate and load the chain token.
module vfa_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     vld,
	input  vfa_pkg::cmd_t                            cmd,
	input  vfa_pkg::word_t [vfa_pkg::COMPONENTS-1:0] a,
	input  vfa_pkg::word_t [vfa_pkg::COMPONENTS-1:0] b,
	input  vfa_pkg::word_t                           s,
	output vfa_pkg::token_t                          tok
);
	import vfa_pkg::*;

	logic signed [31:0] op_c   [COMPONENTS];
	logic signed [63:0] prod_c [COMPONENTS];
	logic signed [32:0] lin_c  [COMPONENTS];
	logic        [31:0] abs_c  [COMPONENTS];

	logic               vld_s1;
	cmd_t               cmd_s1;
	logic signed [63:0] prod_s1 [COMPONENTS];
	logic signed [32:0] lin_s1  [COMPONENTS];
	logic        [31:0] abs_s1  [COMPONENTS];
	logic [COMPONENTS-1:0] neg_s1;

	logic signed [65:0] dot_sum_c;
	logic        [63:0] sq_sum_c;
	sat_t               dot_sat_c;
	sat_t               lane_sat_c [COMPONENTS];
	token_t             tok_c;
	logic                           tok_vld_s2;
	logic [$bits(token_t)-2:0]      tok_dat_s2;

	// Pick multiplier operand and the linear result per lane
	always_comb begin
		for (int i = 0; i < COMPONENTS; i++) begin
			case (cmd)
				CMD_DOT:   op_c[i] = b[i];
				CMD_SCALE: op_c[i] = s;
				default:   op_c[i] = a[i];
			endcase
			prod_c[i] = a[i] * op_c[i];
			case (cmd)
				CMD_ADD: lin_c[i] = 33'(a[i]) + 33'(b[i]);
				CMD_SUB: lin_c[i] = 33'(a[i]) - 33'(b[i]);
				CMD_NEG: lin_c[i] = -33'(a[i]);
				default: lin_c[i] = '0;
			endcase
			abs_c[i] = a[i][31] ? (~a[i] + 32'd1) : a[i];
		end
	end

	// Hold stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
		for (int i = 0; i < COMPONENTS; i++) begin
			prod_s1[i] <= prod_c[i];
			lin_s1[i]  <= lin_c[i];
			abs_s1[i]  <= abs_c[i];
			neg_s1[i]  <= a[i][31];
		end
	end

	// Combine products and saturate
	always_comb begin
		dot_sum_c = 66'(prod_s1[0]) + 66'(prod_s1[1]) + 66'(prod_s1[2]);
		sq_sum_c  = $unsigned(prod_s1[0]) + $unsigned(prod_s1[1]) + $unsigned(prod_s1[2]);
		dot_sat_c = sat32(dot_sum_c >>> FRAC_BITS);
		for (int i = 0; i < COMPONENTS; i++) begin
			if (cmd_s1 == CMD_SCALE) begin
				lane_sat_c[i] = sat32(66'(prod_s1[i] >>> FRAC_BITS));
			end else begin
				lane_sat_c[i] = sat32(66'(lin_s1[i]));
			end
		end

		tok_c       = '0;
		tok_c.valid = vld_s1;
		tok_c.cmd   = cmd_s1;
		tok_c.n     = sq_sum_c;
		for (int i = 0; i < COMPONENTS; i++) begin
			tok_c.neg[i]  = neg_s1[i];
			tok_c.drem[i] = {abs_s1[i], 16'd0};
		end
		case (cmd_s1)
			CMD_ADD, CMD_SUB, CMD_NEG, CMD_SCALE: begin
				for (int i = 0; i < COMPONENTS; i++) begin
					tok_c.r[i] = lane_sat_c[i].val;
				end
				tok_c.ov = lane_sat_c[0].ov | lane_sat_c[1].ov | lane_sat_c[2].ov;
			end
			CMD_DOT: begin
				tok_c.scal = dot_sat_c.val;
				tok_c.ov   = dot_sat_c.ov;
			end
			default: begin
				tok_c.ov = 1'b0;
			end
		endcase
	end

	// Hold stage two valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_s2 <= 1'b0;
		end else begin
			tok_vld_s2 <= tok_c.valid;
		end
	end

	// Stage two payload
	always_ff @(posedge clk) begin
		tok_dat_s2 <= tok_c[$bits(token_t)-2:0];
	end

	assign tok = {tok_vld_s2, tok_dat_s2};

endmodule

// ===== hdl/vfa_sqrt_cell.sv =====
// Square root cell: resolves one root bit from two radicand bits.
module vfa_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  vfa_pkg::token_t tin,
	output vfa_pkg::token_t tout
);
	import vfa_pkg::*;

	logic [35:0] shifted_c;
	logic [35:0] trial_c;
	token_t      tok_c;
	logic                      tok_vld_q;
	logic [$bits(token_t)-2:0] tok_dat_q;

	// Bring down two bits and try the next root bit
	always_comb begin
		tok_c     = tin;
		shifted_c = {tin.rem[33:0], tin.n[63:62]};
		trial_c   = {2'b00, tin.root, 2'b01};
		tok_c.n   = {tin.n[61:0], 2'b00};
		if (shifted_c >= trial_c) begin
			tok_c.rem  = shifted_c - trial_c;
			tok_c.root = {tin.root[30:0], 1'b1};
		end else begin
			tok_c.rem  = shifted_c;
			tok_c.root = {tin.root[30:0], 1'b0};
		end
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_c.valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		tok_dat_q <= tok_c[$bits(token_t)-2:0];
	end

	assign tout = {tok_vld_q, tok_dat_q};

endmodule

// ===== hdl/vfa_div_cell.sv =====
// Divide cell: resolves one quotient bit in every lane against the length.
module vfa_div_cell #(
	parameter int SHIFT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vfa_pkg::token_t tin,
	output vfa_pkg::token_t tout
);
	import vfa_pkg::*;

	logic [47:0] dvs_c;
	token_t      tok_c;
	logic                      tok_vld_q;
	logic [$bits(token_t)-2:0] tok_dat_q;

	// Subtract the shifted divisor where it fits
	always_comb begin
		tok_c = tin;
		dvs_c = {16'd0, tin.root} << SHIFT;
		for (int i = 0; i < COMPONENTS; i++) begin
			if (tin.drem[i] >= dvs_c) begin
				tok_c.drem[i]       = tin.drem[i] - dvs_c;
				tok_c.quo[i][SHIFT] = 1'b1;
			end
		end
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_c.valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		tok_dat_q <= tok_c[$bits(token_t)-2:0];
	end

	assign tout = {tok_vld_q, tok_dat_q};

endmodule

// ===== hdl/vector3_fixed_point_alu.sv =====
// Top level of the three-component Q16.16 vector unit.
//
// Commands enter on start with the command code, vectors a and b and the
// scale factor; a transaction is taken at each rising edge with start high
// and busy low. busy never rises, so one transaction may enter every cycle.
// Each transaction gives one result on r_x, r_y, r_z, result_scalar and
// status, marked by done for exactly one cycle, in order of entry.
// Every command takes the same path: two front stages (multiply, then sum
// and saturate), 32 square root cells at one root bit each, 17 divide cells
// at one quotient bit each, and the output register.
// Throughput is one transaction per cycle; the root and divide cells are
// separate pipeline stages, so every cell holds a different transaction.
// The receiver cannot stall: a result is on the ports for one cycle only.
// Reset clears every valid bit in the chain and the done strobe; data in
// flight is dropped.
module vector3_fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] scale_factor,
	output logic        done,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] result_scalar,
	output logic [1:0]  status
);
	import vfa_pkg::*;

	localparam int CELLS = SQRT_CELLS + DIV_BITS;

	token_t tok [CELLS+1];
	token_t last;
	word_t [COMPONENTS-1:0] a_vec;
	word_t [COMPONENTS-1:0] b_vec;

	logic [COMPONENTS-1:0][31:0] r_c;
	logic [31:0] scal_c;
	status_t     status_c;

	logic        done_q;
	logic [31:0] r_x_q, r_y_q, r_z_q, scal_q;
	status_t     status_q;

	assign busy  = 1'b0;
	assign a_vec = {a_z, a_y, a_x};
	assign b_vec = {b_z, b_y, b_x};

	vfa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start & ~busy),
		.cmd    (cmd_t'(command)),
		.a      (a_vec),
		.b      (b_vec),
		.s      (scale_factor),
		.tok    (tok[0])
	);

	// Square root chain
	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		vfa_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (tok[k]),
			.tout   (tok[k+1])
		);
	end

	// Divide chain, most significant quotient bit first
	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		vfa_div_cell #(
			.SHIFT (DIV_BITS - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (tok[SQRT_CELLS+k]),
			.tout   (tok[SQRT_CELLS+k+1])
		);
	end

	assign last = tok[CELLS];

	// Finish length and normalize, pass the rest
	always_comb begin
		r_c      = '0;
		scal_c   = '0;
		status_c = ST_OK;
		case (last.cmd)
			CMD_ADD, CMD_SUB, CMD_NEG, CMD_SCALE: begin
				r_c      = last.r;
				status_c = last.ov ? ST_OVF : ST_OK;
			end
			CMD_DOT: begin
				scal_c   = last.scal;
				status_c = last.ov ? ST_OVF : ST_OK;
			end
			CMD_LENGTH: begin
				if (last.root[31]) begin
					scal_c   = 32'h7FFF_FFFF;
					status_c = ST_OVF;
				end else begin
					scal_c = last.root;
				end
			end
			CMD_NORM: begin
				if (last.root == 32'd0) begin
					status_c = ST_ZERO;
				end else begin
					for (int i = 0; i < COMPONENTS; i++) begin
						r_c[i] = last.neg[i] ? (32'd0 - 32'(last.quo[i]))
						                     : 32'(last.quo[i]);
					end
				end
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	// Strobe the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		r_x_q    <= r_c[0];
		r_y_q    <= r_c[1];
		r_z_q    <= r_c[2];
		scal_q   <= scal_c;
		status_q <= status_c;
	end

	assign done          = done_q;
	assign r_x           = r_x_q;
	assign r_y           = r_y_q;
	assign r_z           = r_z_q;
	assign result_scalar = scal_q;
	assign status        = status_q;

endmodule

// ===== sim/vector3_fixed_point_alu_tb.sv =====
// Self-checking testbench for the three-component Q16.16 vector unit.
`timescale 1ns / 1ps

module vector3_fixed_point_alu_tb;
	import vfa_pkg::*;

	localparam int LATENCY = 52;
	localparam int N_RANDOM = 950;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef struct {
		logic [2:0] cmd;
		logic signed [31:0] ax, ay, az, bx, by, bz, sf;
	} vec_cmd_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz, scal;
		logic [1:0] st;
	} vec_res_t;

	typedef struct {
		vec_cmd_t c;
		logic has_exp;
		vec_res_t e;
	} dir_row_t;

	logic clk, arst_n, start, busy, done;
	logic [2:0] command;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
	logic signed [31:0] r_x, r_y, r_z, result_scalar;
	logic [1:0] status;

	vec_res_t pending_results[$];
	int errors = 0;
	int n_checked = 0;
	int n_sent = 0;
	int cmd_hits[8];
	bit stim_done = 0;

	vector3_fixed_point_alu u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .scale_factor(scale_factor),
		.done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z),
		.result_scalar(result_scalar), .status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Saturate a wide value to 32 bits, flag overflow
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
			inout logic ov);
		if (v > 128'sh7FFF_FFFF) begin
			ov = 1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -128'sh8000_0000) begin
			ov = 1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Floor of the square root of a 64-bit value, bit by bit
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// Compute the expected result of one vector command
	function automatic vec_res_t vector_alu_predict(input vec_cmd_t c);
		vec_res_t o;
		logic signed [127:0] a[3], b[3], s, acc, len;
		logic [63:0] sum;
		logic ov;
		ov = 0;
		o = '{default: '0};
		a[0] = 128'(c.ax); a[1] = 128'(c.ay); a[2] = 128'(c.az);
		b[0] = 128'(c.bx); b[1] = 128'(c.by); b[2] = 128'(c.bz);
		s = 128'(c.sf);
		case (c.cmd)
			CMD_ADD: begin
				o.rx = clamp32(a[0] + b[0], ov);
				o.ry = clamp32(a[1] + b[1], ov);
				o.rz = clamp32(a[2] + b[2], ov);
			end
			CMD_SUB: begin
				o.rx = clamp32(a[0] - b[0], ov);
				o.ry = clamp32(a[1] - b[1], ov);
				o.rz = clamp32(a[2] - b[2], ov);
			end
			CMD_DOT: begin
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				o.scal = clamp32(acc >>> 16, ov);
			end
			CMD_SCALE: begin
				o.rx = clamp32((a[0] * s) >>> 16, ov);
				o.ry = clamp32((a[1] * s) >>> 16, ov);
				o.rz = clamp32((a[2] * s) >>> 16, ov);
			end
			CMD_LENGTH, CMD_NORM: begin
				sum = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
				len = {64'd0, floor_root(sum)};
				if (c.cmd == CMD_LENGTH)
					o.scal = clamp32(len, ov);
				else if (len == 0)
					o.st = ST_ZERO;
				else begin
					// Signed division truncates toward zero
					o.rx = 32'((a[0] * 65536) / len);
					o.ry = 32'((a[1] * 65536) / len);
					o.rz = 32'((a[2] * 65536) / len);
				end
			end
			CMD_NEG: begin
				o.rx = clamp32(-a[0], ov);
				o.ry = clamp32(-a[1], ov);
				o.rz = clamp32(-a[2], ov);
			end
			default: ;
		endcase
		if (ov)
			o.st = ST_OVF;
		return o;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 0;
			3, 4: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
			default: return $urandom;
		endcase
	endfunction

	// Drive one transaction and wait for acceptance
	task automatic send_cmd(input vec_cmd_t c, input logic has_exp, input vec_res_t e);
		vec_res_t p;
		command <= c.cmd;
		a_x <= c.ax; a_y <= c.ay; a_z <= c.az;
		b_x <= c.bx; b_y <= c.by; b_z <= c.bz;
		scale_factor <= c.sf;
		start <= 1;
		do @(posedge clk); while (busy);
		p = vector_alu_predict(c);
		if (has_exp && p != e) begin
			$display("%0t: table row disagrees with prediction for cmd %0d", $time, c.cmd);
			errors++;
		end
		pending_results.push_back(has_exp ? e : p);
		cmd_hits[c.cmd]++;
		n_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		if ($urandom_range(0, 2) != 0)
			return;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
		start <= 0;
		repeat (g) @(negedge clk);
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		vec_res_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
			end else begin
				e = pending_results.pop_front();
				n_checked++;
				if (r_x !== e.rx) begin
					$display("%0t: r_x exp %h got %h", $time, e.rx, r_x);
					errors++;
				end
				if (r_y !== e.ry) begin
					$display("%0t: r_y exp %h got %h", $time, e.ry, r_y);
					errors++;
				end
				if (r_z !== e.rz) begin
					$display("%0t: r_z exp %h got %h", $time, e.rz, r_z);
					errors++;
				end
				if (result_scalar !== e.scal) begin
					$display("%0t: result_scalar exp %h got %h", $time, e.scal,
						result_scalar);
					errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status exp %0d got %0d", $time, e.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t rows[$];
		vec_cmd_t c;
		vec_res_t z;
		int w;
		logic signed [31:0] MAXW, MINW, ONE;
		MAXW = 32'sh7FFF_FFFF; MINW = 32'sh8000_0000; ONE = 32'sh1_0000;
		z = '{default: '0};
		// Table: command, a, b, scale, typed expectation where obvious
		rows.push_back('{'{CMD_ADD, 0, 0, 0, 0, 0, 0, 0}, 1, z});
		rows.push_back('{'{CMD_ADD, MAXW, MINW, 1, 1, -1, 0, 0}, 1,
			'{MAXW, MINW, 1, 0, ST_OVF}});
		rows.push_back('{'{CMD_SUB, MINW, 5, MAXW, 1, 0, 0, 0}, 1,
			'{MINW, 5, 32'sh7FFF_FFFF, 0, ST_OVF}});
		rows.push_back('{'{CMD_DOT, ONE, ONE, ONE, ONE, 2 * ONE, -ONE, 0}, 1,
			'{0, 0, 0, 2 * ONE, ST_OK}});
		rows.push_back('{'{CMD_DOT, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, 0}, 1,
			'{0, 0, 0, MAXW, ST_OVF}});
		rows.push_back('{'{CMD_DOT, MINW, MINW, 0, MAXW, MAXW, 0, 0}, 0, z});
		rows.push_back('{'{CMD_DOT, -1, 1, 0, 1, 0, 0, 0}, 0, z});
		rows.push_back('{'{CMD_SCALE, ONE, -ONE, MAXW, 0, 0, 0, 2 * ONE}, 1,
			'{2 * ONE, -2 * ONE, MAXW, 0, ST_OVF}});
		rows.push_back('{'{CMD_SCALE, MINW, MAXW, -1, 0, 0, 0, MINW}, 0, z});
		rows.push_back('{'{CMD_LENGTH, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0}, 1,
			'{0, 0, 0, 5 * ONE, ST_OK}});
		rows.push_back('{'{CMD_LENGTH, MINW, MINW, MINW, 0, 0, 0, 0}, 1,
			'{0, 0, 0, MAXW, ST_OVF}});
		rows.push_back('{'{CMD_LENGTH, 0, 0, 0, 0, 0, 0, 0}, 1, z});
		rows.push_back('{'{CMD_NORM, 0, 0, 0, 7, 7, 7, 7}, 1,
			'{0, 0, 0, 0, ST_ZERO}});
		rows.push_back('{'{CMD_NORM, 5 * ONE, 0, 0, 0, 0, 0, 0}, 1,
			'{ONE, 0, 0, 0, ST_OK}});
		rows.push_back('{'{CMD_NORM, MINW, MAXW, MINW, 0, 0, 0, 0}, 0, z});
		rows.push_back('{'{CMD_NORM, 1, -1, 0, 0, 0, 0, 0}, 0, z});
		rows.push_back('{'{CMD_NEG, MINW, MAXW, 0, 0, 0, 0, 0}, 1,
			'{MAXW, -MAXW, 0, 0, ST_OVF}});
		rows.push_back('{'{CMD_NEG, 1, -1, ONE, 0, 0, 0, 0}, 1,
			'{-1, 1, -ONE, 0, ST_OK}});
		rows.push_back('{'{CMD_UNUSED, MAXW, MINW, 1, 2, 3, 4, 5}, 1, z});

		start = 0; command = 0;
		a_x = 0; a_y = 0; a_z = 0; b_x = 0; b_y = 0; b_z = 0; scale_factor = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed table, back to back
		foreach (rows[i])
			send_cmd(rows[i].c, rows[i].has_exp, rows[i].e);

		// Random transactions with gaps on the sender side
		for (int i = 0; i < N_RANDOM; i++) begin
			c.cmd = 3'($urandom_range(0, 7));
			c.ax = rand_word(); c.ay = rand_word(); c.az = rand_word();
			c.bx = rand_word(); c.by = rand_word(); c.bz = rand_word();
			c.sf = rand_word();
			if (c.cmd == CMD_NORM && $urandom_range(0, 7) == 0) begin
				c.ax = 0; c.ay = 0; c.az = 0;
			end
			send_cmd(c, 0, z);
			idle_gap();
		end
		start <= 0;

		w = 0;
		while (pending_results.size() != 0 && w < 10 * LATENCY + 100) begin
			@(posedge clk);
			w++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results", n_sent, n_checked);
		$display("Per command: add %0d sub %0d dot %0d scale %0d len %0d norm %0d neg %0d unused %0d",
			cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4],
			cmd_hits[5], cmd_hits[6], cmd_hits[7]);
		if (errors == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
